/* rtl/fofr_pkg.sv */
`timescale 1ns / 1ps
package fofr_pkg;

  typedef enum logic [1:0] {
    CMD_ADD_PLAYER = 2'd0,
    CMD_ADD_EDGE   = 2'd1,
    CMD_RECOMMEND  = 2'd2,
    CMD_UNUSED     = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_UNKNOWN = 2'd1,
    ST_FULL    = 2'd2,
    ST_REC     = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOOK,
    S_LOOK_WAIT,
    S_EDGE_A,
    S_EDGE_B,
    S_SRC_RD,
    S_SRC_WAIT,
    S_FRIEND,
    S_FRIEND_WAIT,
    S_SEL,
    S_EMIT,
    S_RESP
  } fsm_t;

  localparam int unsigned ID_W     = 16;
  localparam int unsigned SCORE_W  = 5;
  localparam int unsigned TOP_W    = 4;
  localparam int unsigned REG_TOP  = 0;
  localparam logic [TOP_W-1:0] TOP_RESET = 4'd3;

endpackage

/* rtl/fofr_id_mem.sv */
`timescale 1ns / 1ps
module fofr_id_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [fofr_pkg::ID_W-1:0]   wdata,
  input  logic [AW-1:0]               raddr,
  output logic [fofr_pkg::ID_W-1:0]   rdata
);

  logic [fofr_pkg::ID_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/fofr_row_mem.sv */
`timescale 1ns / 1ps
module fofr_row_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [DEPTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [DEPTH-1:0] rdata
);

  // rows are always written (zeroed) when their slot is allocated, so no clear pass
  logic [DEPTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/friend_of_friend_recommender.sv */
`timescale 1ns / 1ps
// Friend-of-friend recommender. One command is handled at a time. Add player writes
// the id and a zeroed row into the next free slot. Add edge does an id lookup over the
// filled slots, then a read-modify-write of both rows. Recommend does the lookup, the
// source row read and the friend row walk, then one selection pass over the filled
// slots for each recommendation. Stalls on the result channel hold the reply states
// until the result register is free. Ids and neighbor rows sit in two single-port-read
// memories with registered reads. Each result waits in an output register; in_stall is
// high while a command is in progress, and the next command can be taken while the last
// result still waits.
module friend_of_friend_recommender #(
  parameter int unsigned MAX_PLAYERS = 16,
  parameter int unsigned MAX_TOP     = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_cmd,
  input  logic [fofr_pkg::ID_W-1:0]     in_id_a,
  input  logic [fofr_pkg::ID_W-1:0]     in_id_b,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_status,
  output logic [fofr_pkg::ID_W-1:0]     out_rec_id,
  output logic [fofr_pkg::SCORE_W-1:0]  out_rec_score,
  output logic                          out_last,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int unsigned AW = (MAX_PLAYERS > 1) ? $clog2(MAX_PLAYERS) : 1;
  localparam int unsigned CW = $clog2(MAX_PLAYERS + 1);
  localparam int unsigned NW = $clog2(MAX_TOP + 1);
  localparam logic [CW-1:0] FULL = CW'(MAX_PLAYERS);

  // config
  logic [fofr_pkg::TOP_W-1:0] top_r;
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == 1'b0) ? {28'd0, top_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r <= fofr_pkg::TOP_RESET;
    end else if (cfg_wr && paddr[2] == 1'b0) begin
      top_r <= pwdata[fofr_pkg::TOP_W-1:0];
    end
  end

  logic [NW-1:0] limit;
  assign limit = (32'(top_r) > MAX_TOP) ? NW'(MAX_TOP) : NW'(top_r);

  // memories
  logic                      id_we;
  logic [AW-1:0]             id_waddr, id_raddr;
  logic [fofr_pkg::ID_W-1:0] id_wdata, id_rdata;
  logic                      row_we;
  logic [AW-1:0]             row_waddr, row_raddr;
  logic [MAX_PLAYERS-1:0]    row_wdata, row_rdata;

  fofr_id_mem #(.DEPTH(MAX_PLAYERS), .AW(AW)) u_ids (
    .clk(clk), .we(id_we), .waddr(id_waddr), .wdata(id_wdata),
    .raddr(id_raddr), .rdata(id_rdata)
  );
  fofr_row_mem #(.DEPTH(MAX_PLAYERS), .AW(AW)) u_rows (
    .clk(clk), .we(row_we), .waddr(row_waddr), .wdata(row_wdata),
    .raddr(row_raddr), .rdata(row_rdata)
  );

  fofr_pkg::fsm_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [1:0]    cmd_r, cmd_nxt;
  logic [fofr_pkg::ID_W-1:0] ida_r, ida_nxt, idb_r, idb_nxt;
  logic [CW-1:0] ptr_r, ptr_nxt;     // walk position
  logic          fa_r, fa_nxt, fb_r, fb_nxt;
  logic [AW-1:0] sa_r, sa_nxt, sb_r, sb_nxt;
  logic [MAX_PLAYERS-1:0] srow_r, srow_nxt, skip_r, skip_nxt, taken_r, taken_nxt;
  logic [fofr_pkg::SCORE_W-1:0] score_r [MAX_PLAYERS];
  logic [fofr_pkg::SCORE_W-1:0] score_nxt [MAX_PLAYERS];
  logic          bfound_r, bfound_nxt;
  logic [AW-1:0] best_r, best_nxt;
  logic [fofr_pkg::SCORE_W-1:0] bscore_r, bscore_nxt;
  logic [NW-1:0] n_r, n_nxt;
  logic [1:0]    pst_r, pst_nxt;     // status of the single-result reply
  logic          ov_r, ov_nxt, olast_r, olast_nxt;
  logic [1:0]    ost_r, ost_nxt;
  logic [fofr_pkg::ID_W-1:0]    oid_r, oid_nxt;
  logic [fofr_pkg::SCORE_W-1:0] osc_r, osc_nxt;

  assign in_stall      = (state_r != fofr_pkg::S_IDLE);
  assign out_valid     = ov_r;
  assign out_status    = ost_r;
  assign out_rec_id    = oid_r;
  assign out_rec_score = osc_r;
  assign out_last      = olast_r;

  logic out_free;
  assign out_free = !ov_r || !out_stall;

  logic [AW-1:0] ptr_a;
  assign ptr_a = ptr_r[AW-1:0];

  // slots still carrying a nonzero score
  logic [MAX_PLAYERS-1:0] remain_mask;
  always_comb begin
    for (int c = 0; c < MAX_PLAYERS; c++) begin
      remain_mask[c] = (score_r[c] != '0) && (CW'(c) < count_r);
    end
  end

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    cmd_nxt = cmd_r; ida_nxt = ida_r; idb_nxt = idb_r;
    ptr_nxt = ptr_r;
    fa_nxt = fa_r; fb_nxt = fb_r; sa_nxt = sa_r; sb_nxt = sb_r;
    srow_nxt = srow_r; skip_nxt = skip_r; taken_nxt = taken_r;
    score_nxt = score_r;
    bfound_nxt = bfound_r; best_nxt = best_r; bscore_nxt = bscore_r;
    n_nxt = n_r;
    pst_nxt = pst_r;
    ov_nxt = ov_r && out_stall;
    ost_nxt = ost_r; oid_nxt = oid_r; osc_nxt = osc_r; olast_nxt = olast_r;
    id_we = 1'b0; id_waddr = count_r[AW-1:0]; id_wdata = ida_r;
    id_raddr = ptr_a;
    row_we = 1'b0; row_waddr = count_r[AW-1:0]; row_wdata = '0;
    row_raddr = ptr_a;

    case (state_r)
      fofr_pkg::S_IDLE: begin
        if (in_valid && !in_stall) begin
          cmd_nxt = in_cmd; ida_nxt = in_id_a; idb_nxt = in_id_b;
          ptr_nxt = '0; fa_nxt = 1'b0; fb_nxt = 1'b0;
          case (fofr_pkg::cmd_t'(in_cmd))
            fofr_pkg::CMD_ADD_PLAYER: begin
              if (count_r >= FULL) begin
                pst_nxt = fofr_pkg::ST_FULL;
              end else begin
                id_we = 1'b1; id_wdata = in_id_a;
                row_we = 1'b1; row_wdata = '0;
                count_nxt = count_r + 1'b1;
                pst_nxt = fofr_pkg::ST_DONE;
              end
              state_nxt = fofr_pkg::S_RESP;
            end
            fofr_pkg::CMD_ADD_EDGE, fofr_pkg::CMD_RECOMMEND: begin
              state_nxt = fofr_pkg::S_LOOK;
            end
            default: begin
              pst_nxt = fofr_pkg::ST_UNKNOWN;
              state_nxt = fofr_pkg::S_RESP;
            end
          endcase
        end
      end
      fofr_pkg::S_LOOK: begin
        // issue id read at ptr, or finish the walk
        if (ptr_r >= count_r) begin
          if (!fa_r || (cmd_r == fofr_pkg::CMD_ADD_EDGE && !fb_r)) begin
            pst_nxt = fofr_pkg::ST_UNKNOWN;
            state_nxt = fofr_pkg::S_RESP;
          end else if (cmd_r == fofr_pkg::CMD_ADD_EDGE) begin
            row_raddr = sa_r;
            state_nxt = fofr_pkg::S_EDGE_A;
          end else begin
            row_raddr = sa_r;
            state_nxt = fofr_pkg::S_SRC_WAIT;
          end
        end else begin
          state_nxt = fofr_pkg::S_LOOK_WAIT;
        end
      end
      fofr_pkg::S_LOOK_WAIT: begin
        if (!fa_r && id_rdata == ida_r) begin
          fa_nxt = 1'b1; sa_nxt = ptr_a;
        end
        if (!fb_r && id_rdata == idb_r) begin
          fb_nxt = 1'b1; sb_nxt = ptr_a;
        end
        ptr_nxt = ptr_r + 1'b1;
        state_nxt = fofr_pkg::S_LOOK;
      end
      fofr_pkg::S_EDGE_A: begin
        // row a arrives; write it, then read row b
        row_we = 1'b1; row_waddr = sa_r;
        row_wdata = row_rdata | (MAX_PLAYERS'(1) << sb_r);
        state_nxt = fofr_pkg::S_SRC_RD;
      end
      fofr_pkg::S_SRC_RD: begin
        row_raddr = sb_r;
        state_nxt = fofr_pkg::S_EDGE_B;
      end
      fofr_pkg::S_EDGE_B: begin
        row_we = 1'b1; row_waddr = sb_r;
        row_wdata = row_rdata | (MAX_PLAYERS'(1) << sa_r);
        pst_nxt = fofr_pkg::ST_DONE;
        state_nxt = fofr_pkg::S_RESP;
      end
      fofr_pkg::S_SRC_WAIT: begin
        srow_nxt = row_rdata;
        skip_nxt = row_rdata | (MAX_PLAYERS'(1) << sa_r);
        for (int c = 0; c < MAX_PLAYERS; c++) begin
          score_nxt[c] = '0;
        end
        taken_nxt = '0;
        ptr_nxt = '0;
        state_nxt = fofr_pkg::S_FRIEND;
      end
      fofr_pkg::S_FRIEND: begin
        if (ptr_r >= count_r) begin
          ptr_nxt = '0; n_nxt = '0; bfound_nxt = 1'b0;
          if (limit == '0) begin
            pst_nxt = fofr_pkg::ST_DONE;
            state_nxt = fofr_pkg::S_RESP;
          end else begin
            state_nxt = fofr_pkg::S_SEL;
          end
        end else if (srow_r[ptr_a]) begin
          state_nxt = fofr_pkg::S_FRIEND_WAIT;
        end else begin
          ptr_nxt = ptr_r + 1'b1;
        end
      end
      fofr_pkg::S_FRIEND_WAIT: begin
        for (int c = 0; c < MAX_PLAYERS; c++) begin
          if (row_rdata[c] && !skip_r[c] && CW'(c) < count_r && score_r[c] != '1) begin
            score_nxt[c] = score_r[c] + 1'b1;
          end
        end
        ptr_nxt = ptr_r + 1'b1;
        state_nxt = fofr_pkg::S_FRIEND;
      end
      fofr_pkg::S_SEL: begin
        // one slot per cycle; tracks the best by its index, then reads its id at the end of the pass
        if (ptr_r >= count_r) begin
          if (!bfound_r) begin
            if (n_r == '0) begin
              pst_nxt = fofr_pkg::ST_DONE;
              state_nxt = fofr_pkg::S_RESP;
            end else begin
              state_nxt = fofr_pkg::S_IDLE;
            end
          end else begin
            id_raddr = best_r;
            state_nxt = fofr_pkg::S_EMIT;
          end
        end else begin
          if (!taken_r[ptr_a] && score_r[ptr_a] != '0 &&
              (!bfound_r || score_r[ptr_a] > bscore_r)) begin
            bfound_nxt = 1'b1; best_nxt = ptr_a; bscore_nxt = score_r[ptr_a];
          end
          ptr_nxt = ptr_r + 1'b1;
        end
      end
      fofr_pkg::S_EMIT: begin
        // keep the id read on the best slot while the output is blocked
        id_raddr = best_r;
        if (out_free) begin
          ov_nxt = 1'b1;
          ost_nxt = fofr_pkg::ST_REC;
          oid_nxt = id_rdata;
          osc_nxt = bscore_r;
          taken_nxt = taken_r | (MAX_PLAYERS'(1) << best_r);
          n_nxt = n_r + 1'b1;
          if (32'(n_r) + 1 == 32'(limit) ||
              ((taken_nxt | ~remain_mask) == '1)) begin
            olast_nxt = 1'b1;
            state_nxt = fofr_pkg::S_IDLE;
          end else begin
            olast_nxt = 1'b0;
            ptr_nxt = '0; bfound_nxt = 1'b0;
            state_nxt = fofr_pkg::S_SEL;
          end
        end
      end
      fofr_pkg::S_RESP: begin
        if (out_free) begin
          ov_nxt = 1'b1; olast_nxt = 1'b1;
          ost_nxt = pst_r;
          oid_nxt = '0; osc_nxt = '0;
          state_nxt = fofr_pkg::S_IDLE;
        end
      end
      default: state_nxt = fofr_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fofr_pkg::S_IDLE;
      count_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt; ida_r <= ida_nxt; idb_r <= idb_nxt;
    ptr_r <= ptr_nxt;
    fa_r <= fa_nxt; fb_r <= fb_nxt; sa_r <= sa_nxt; sb_r <= sb_nxt;
    srow_r <= srow_nxt; skip_r <= skip_nxt; taken_r <= taken_nxt;
    score_r <= score_nxt;
    bfound_r <= bfound_nxt; best_r <= best_nxt; bscore_r <= bscore_nxt;
    n_r <= n_nxt;
    pst_r <= pst_nxt;
    ost_r <= ost_nxt; oid_r <= oid_nxt; osc_r <= osc_nxt; olast_r <= olast_nxt;
  end

`ifndef SYNTHESIS
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_rec_id))
    else $error("result changed while stalled");
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL)
    else $error("player count overflow");
  a_rec_score: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == fofr_pkg::ST_REC |-> out_rec_score != '0)
    else $error("zero-score recommendation");
`endif

endmodule
